[design/gtss_pkg.sv]
// Package for the granule tag shadow store: sizes, request and state codes,
// and the structs passed between the sequencer, divider and tag memory.
// No dependencies.
`timescale 1ns / 1ps

package gtss_pkg;

  localparam int TAG_ENTRIES = 4096;
  localparam int IDX_W       = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
  localparam int LIMIT_W     = $clog2(TAG_ENTRIES + 1);

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 32;
  localparam int TAG_W       = 8;
  localparam int GRAN_W      = 9;
  localparam int GIU_W       = 13;
  localparam int WRITTEN_W   = 13;

  localparam int QUOT_W      = ADDR_W + 1;
  localparam int DIV_STEPS   = QUOT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_SEL_BIT = 2;
  localparam logic CFG_IDX_GRAN = 1'b0;
  localparam logic CFG_IDX_GIU  = 1'b1;

  localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(16);
  localparam logic [GIU_W-1:0]  GIU_RESET  = GIU_W'(4096);

  typedef enum logic [1:0] {
    REQ_TAG   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_CHECK = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV_FIRST,
    ST_DIV_LAST,
    ST_FILL,
    ST_CHK,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [QUOT_W-1:0] dividend;
    logic [GRAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic [TAG_W-1:0] wr_data;
  } mem_req_t;

endpackage

[design/gtss_if.sv]
// Request and result channel interfaces for the granule tag shadow store.
// Depends on gtss_pkg.
`timescale 1ns / 1ps

interface gtss_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [gtss_pkg::ADDR_W-1:0] addr;
  logic [gtss_pkg::SIZE_W-1:0] size;
  logic [gtss_pkg::TAG_W-1:0]  tag;

  modport source (output valid, req_type, addr, size, tag, input ready);
  modport sink   (input valid, req_type, addr, size, tag, output ready);
endinterface

interface gtss_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_match;
  logic [gtss_pkg::WRITTEN_W-1:0] granules_written;

  modport source (output valid, is_match, granules_written, input ready);
  modport sink   (input valid, is_match, granules_written, output ready);
endinterface

[design/gtss_div.sv]
// Shared restoring divider, one quotient bit per cycle, 33-bit dividend by
// 9-bit divisor. Depends on gtss_pkg.
`timescale 1ns / 1ps

module gtss_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gtss_pkg::div_req_t req,
  output gtss_pkg::div_rsp_t rsp
);
  import gtss_pkg::*;

  logic [QUOT_W-1:0]    q_r, q_nxt;
  logic [GRAN_W-1:0]    rem_r, rem_nxt;
  logic [GRAN_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [GRAN_W:0]      rem_sh;
  logic [GRAN_W:0]      diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_r, q_r[QUOT_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = (rem_sh >= {1'b0, dvs_r});
  end

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[QUOT_W-2:0], ge};
      rem_nxt = ge ? diff[GRAN_W-1:0] : rem_sh[GRAN_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

[design/gtss_tag_mem.sv]
// Tag memory, one entry per granule, with a zeroing sweep after reset and a
// registered read port. Depends on gtss_pkg.
`timescale 1ns / 1ps

module gtss_tag_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gtss_pkg::mem_req_t           req,
  output logic [gtss_pkg::TAG_W-1:0]   rd_data,
  output logic                         clear_busy
);
  import gtss_pkg::*;

  logic [TAG_W-1:0] mem [TAG_ENTRIES];
  logic             clr_active_r, clr_active_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [TAG_W-1:0] rd_data_r;
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [TAG_W-1:0] wd;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    if (clr_active_r) begin
      clr_idx_nxt = clr_idx_r + IDX_W'(1);
      if (clr_idx_r == IDX_W'(TAG_ENTRIES - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
    we = clr_active_r | req.wr_en;
    wa = clr_active_r ? clr_idx_r : req.addr;
    wd = clr_active_r ? '0 : req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_busy = clr_active_r;

endmodule

[design/granule_tag_shadow_store_core.sv]
// Granule tag shadow store top level: config registers, request sequencer,
// result register. Depends on gtss_pkg, gtss_if, gtss_div, gtss_tag_mem.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    req_type, addr, size, tag
//   out_ch   out  valid/ready    is_match, granules_written
//   apb      in   psel/penable   paddr, pwdata -> prdata (pready always high)
//
// After reset a zeroing sweep of every tag entry runs before in_ch.ready rises.
// Tag/clear: two divides on the shared divider, then one memory write per cycle
// for each granule written.
// Check: one divide, then one memory read. Type 3: no divide, straight to the result.
// A finished result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps

module granule_tag_shadow_store_core (
  input  logic                               clk,
  input  logic                               rst_n,
  gtss_in_if.sink                            in_ch,
  gtss_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gtss_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gtss_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gtss_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import gtss_pkg::*;

  seq_state_t             state_r, state_nxt;
  req_type_t              req_r, req_nxt;
  logic [QUOT_W-1:0]      end_r, end_nxt;
  logic [TAG_W-1:0]       tag_r, tag_nxt;
  logic [IDX_W-1:0]       first_r, first_nxt;
  logic [IDX_W-1:0]       last_r, last_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   match_r, match_nxt;
  logic [WRITTEN_W-1:0]   written_r, written_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_match_r, out_match_nxt;
  logic [WRITTEN_W-1:0]   out_written_r, out_written_nxt;
  logic [GRAN_W-1:0]      gran_r, gran_nxt;
  logic [GIU_W-1:0]       giu_r, giu_nxt;

  logic [GRAN_W-1:0]      g_eff;
  logic [LIMIT_W-1:0]     limit;
  logic                   in_acc;
  logic                   cfg_wr;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  mem_req_t               mem_req;
  logic [TAG_W-1:0]       rd_data;
  logic                   clear_busy;

  gtss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gtss_tag_mem u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (mem_req),
    .rd_data    (rd_data),
    .clear_busy (clear_busy)
  );

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    gran_nxt = gran_r;
    giu_nxt  = giu_r;
    if (cfg_wr) begin
      case (paddr[CFG_SEL_BIT])
        CFG_IDX_GRAN: gran_nxt = pwdata[GRAN_W-1:0];
        CFG_IDX_GIU:  giu_nxt  = pwdata[GIU_W-1:0];
        default: ;
      endcase
    end
    case (paddr[CFG_SEL_BIT])
      CFG_IDX_GRAN: prdata = CFG_DATA_W'(gran_r);
      CFG_IDX_GIU:  prdata = CFG_DATA_W'(giu_r);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    g_eff = (gran_r == '0) ? GRAN_W'(1) : gran_r;
    if (LIMIT_W'(giu_r) > LIMIT_W'(TAG_ENTRIES)) begin
      limit = LIMIT_W'(TAG_ENTRIES);
    end else begin
      limit = LIMIT_W'(giu_r);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    end_nxt         = end_r;
    tag_nxt         = tag_r;
    first_nxt       = first_r;
    last_nxt        = last_r;
    idx_nxt         = idx_r;
    match_nxt       = match_r;
    written_nxt     = written_r;
    out_valid_nxt   = out_valid_r & ~out_ch.ready;
    out_match_nxt   = out_match_r;
    out_written_nxt = out_written_r;
    div_req.start    = 1'b0;
    div_req.dividend = end_r;
    div_req.divisor  = g_eff;
    mem_req.wr_en    = 1'b0;
    mem_req.rd_en    = 1'b0;
    mem_req.addr     = idx_r;
    mem_req.wr_data  = (req_r == REQ_TAG) ? tag_r : '0;

    case (state_r)
      ST_CLR: begin
        if (!clear_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt     = req_type_t'(in_ch.req_type);
          tag_nxt     = in_ch.tag;
          end_nxt     = {1'b0, in_ch.addr} + {1'b0, in_ch.size} - QUOT_W'(1);
          match_nxt   = 1'b0;
          written_nxt = '0;
          div_req.dividend = {1'b0, in_ch.addr};
          case (in_ch.req_type)
            REQ_TAG, REQ_CLEAR: begin
              if (in_ch.size == '0) begin
                state_nxt = ST_DONE;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = ST_DIV_FIRST;
              end
            end
            REQ_CHECK: begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV_FIRST;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV_FIRST: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= QUOT_W'(limit)) begin
            state_nxt = ST_DONE;
          end else begin
            first_nxt = div_rsp.quotient[IDX_W-1:0];
            idx_nxt   = div_rsp.quotient[IDX_W-1:0];
            if (req_r == REQ_CHECK) begin
              mem_req.rd_en = 1'b1;
              mem_req.addr  = div_rsp.quotient[IDX_W-1:0];
              state_nxt     = ST_CHK;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV_LAST;
            end
          end
        end
      end
      ST_DIV_LAST: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= QUOT_W'(limit)) begin
            last_nxt = IDX_W'(limit - LIMIT_W'(1));
          end else begin
            last_nxt = div_rsp.quotient[IDX_W-1:0];
          end
          written_nxt = WRITTEN_W'(LIMIT_W'(last_nxt) - LIMIT_W'(first_r) + LIMIT_W'(1));
          state_nxt   = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_req.wr_en = 1'b1;
        idx_nxt       = idx_r + IDX_W'(1);
        if (idx_r == last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHK: begin
        match_nxt = (rd_data == tag_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_match_nxt   = match_r;
          out_written_nxt = written_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
      gran_r      <= GRAN_RESET;
      giu_r       <= GIU_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gran_r      <= gran_nxt;
      giu_r       <= giu_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    end_r         <= end_nxt;
    tag_r         <= tag_nxt;
    first_r       <= first_nxt;
    last_r        <= last_nxt;
    idx_r         <= idx_nxt;
    match_r       <= match_nxt;
    written_r     <= written_nxt;
    out_match_r   <= out_match_nxt;
    out_written_r <= out_written_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.is_match         = out_match_r;
  assign out_ch.granules_written = out_written_r;

endmodule

[design/gtss_checker.sv]
// Port-level checks for the granule tag shadow store, bound to the top level.
// Depends on gtss_pkg, gtss_if, granule_tag_shadow_store_core.
`timescale 1ns / 1ps

module gtss_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           is_match,
  input logic [gtss_pkg::WRITTEN_W-1:0] granules_written
);
  import gtss_pkg::*;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous request in flight");

  a_written_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> granules_written <= WRITTEN_W'(TAG_ENTRIES))
    else $error("granules_written above store depth");

  a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(is_match && granules_written != '0))
    else $error("match reported on a write request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(is_match) && $stable(granules_written))
    else $error("stalled result changed");

endmodule

bind granule_tag_shadow_store_core gtss_checker u_gtss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .is_match         (out_ch.is_match),
  .granules_written (out_ch.granules_written)
);

[test/tag_store_checker.sv]
// Checker for the granule tag shadow store: watches the request, result and register
// ports, keeps its own shadow of the tag memory and compares every result in order.
// Depends on gtss_pkg and gtss_if.
`timescale 1ns / 1ps

module tag_store_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  gtss_in_if                              req_ch,
  gtss_out_if                             res_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [gtss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gtss_pkg::CFG_DATA_W-1:0] pwdata,
  output int unsigned                     mismatches,
  output int unsigned                     outstanding,
  output int unsigned                     tag_hits
);
  import gtss_pkg::*;

  typedef struct packed {
    logic                 is_match;
    logic [WRITTEN_W-1:0] granules_written;
  } tag_result_t;

  logic [TAG_W-1:0]  shadow_tags [TAG_ENTRIES];
  logic [GRAN_W-1:0] gran_size;
  logic [GIU_W-1:0]  in_use;
  tag_result_t       awaited_results [$];
  int unsigned       fail_total;
  int unsigned       hit_total;

  function automatic tag_result_t apply_request(input logic [1:0]        kind,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [SIZE_W-1:0] size,
                                                input logic [TAG_W-1:0]  tag);
    tag_result_t r;
    logic [32:0] gsz, lim, first, last, idx;
    r   = '0;
    gsz = (gran_size == '0) ? 33'd1 : 33'(gran_size);
    lim = (in_use > TAG_ENTRIES) ? 33'(TAG_ENTRIES) : 33'(in_use);
    case (kind)
      REQ_TAG, REQ_CLEAR: begin
        if (size != '0) begin
          first = 33'(addr) / gsz;
          last  = (33'(addr) + 33'(size) - 33'd1) / gsz;
          if (first < lim) begin
            if (last > lim - 33'd1) last = lim - 33'd1;
            for (idx = first; idx <= last; idx++)
              shadow_tags[idx[IDX_W-1:0]] = (kind == REQ_TAG) ? tag : '0;
            r.granules_written = WRITTEN_W'(last - first + 33'd1);
          end
        end
      end
      REQ_CHECK: begin
        idx = 33'(addr) / gsz;
        r.is_match = (idx < lim) && (shadow_tags[idx[IDX_W-1:0]] == tag);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    tag_result_t want;
    tag_result_t pred;
    if (!rst_n) begin
      foreach (shadow_tags[i]) shadow_tags[i] = '0;
      gran_size  = GRAN_RESET;
      in_use     = GIU_RESET;
      awaited_results.delete();
      fail_total = 0;
      hit_total  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request pending: is_match %0d granules_written %0d",
                 res_ch.is_match, res_ch.granules_written);
          fail_total++;
        end else begin
          want = awaited_results.pop_front();
          if (res_ch.is_match !== want.is_match) begin
            $error("is_match: expected %0d, got %0d", want.is_match, res_ch.is_match);
            fail_total++;
          end
          if (res_ch.granules_written !== want.granules_written) begin
            $error("granules_written: expected %0d, got %0d",
                   want.granules_written, res_ch.granules_written);
            fail_total++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pred = apply_request(req_ch.req_type, req_ch.addr, req_ch.size, req_ch.tag);
        if (pred.is_match) hit_total++;
        awaited_results = {awaited_results, pred};
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[CFG_SEL_BIT] == CFG_IDX_GRAN) gran_size = pwdata[GRAN_W-1:0];
        else in_use = pwdata[GIU_W-1:0];
      end
    end
    mismatches  <= fail_total;
    outstanding <= awaited_results.size();
    tag_hits    <= hit_total;
  end

endmodule

[test/tb_granule_tag_shadow_store_core.sv]
// Top of the granule tag shadow store testbench: clock, reset, register writes,
// request stimulus under several idle patterns, and the final verdict.
// Depends on gtss_pkg, gtss_if, granule_tag_shadow_store_core and tag_store_checker.
`timescale 1ns / 1ps

module tb_granule_tag_shadow_store_core;
  import gtss_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] GRAN_ADDR = CFG_ADDR_W'(CFG_IDX_GRAN) << CFG_SEL_BIT;
  localparam logic [CFG_ADDR_W-1:0] GIU_ADDR  = CFG_ADDR_W'(CFG_IDX_GIU) << CFG_SEL_BIT;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int HOLD_CYCLES     = 500;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int unsigned GRAN_PLAN [PHASES] = '{16, 1, 256, 0, 511, 64, 3, 0};
  localparam int unsigned GIU_PLAN  [PHASES] = '{4096, 1, 100, 0, 8191, 4096, 37, 0};

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  gtss_in_if  req_ch ();
  gtss_out_if res_ch ();

  int unsigned mismatches, outstanding, tag_hits;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_requests;
  int unsigned sent;
  int unsigned quiet_cycles;
  logic [GRAN_W-1:0] cur_gran;
  logic [GIU_W-1:0]  cur_giu;
  logic [ADDR_W-1:0] last_addr;
  logic [SIZE_W-1:0] last_len;
  logic [TAG_W-1:0]  last_tag;

  always #2 clk = ~clk;

  granule_tag_shadow_store_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tag_store_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ch      (req_ch),
    .res_ch      (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .tag_hits    (tag_hits)
  );

  // result side: random stalls, plus a long hold when asked
  initial begin
    int unsigned hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_req(input logic [1:0] kind, input logic [ADDR_W-1:0] a,
                          input logic [SIZE_W-1:0] s, input logic [TAG_W-1:0] t);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.addr     <= a;
    req_ch.size     <= s;
    req_ch.tag      <= t;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5A;
      3: return 8'hA5;
      default: return TAG_W'($urandom);
    endcase
  endfunction

  task automatic random_request();
    logic [1:0]        kind;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] s;
    logic [TAG_W-1:0]  t;
    int unsigned gb, lim, span, roll;
    gb   = (cur_gran == '0) ? 1 : cur_gran;
    lim  = (cur_giu > TAG_ENTRIES) ? TAG_ENTRIES : cur_giu;
    span = (lim + 2) * gb;
    roll = $urandom_range(0, 99);
    if (roll < 3) kind = REQ_UNUSED;
    else if (roll < 45) kind = REQ_TAG;
    else if (roll < 55) kind = REQ_CLEAR;
    else kind = REQ_CHECK;
    t    = pick_tag();
    roll = $urandom_range(0, 99);
    if (roll < 5) a = $urandom;
    else if (kind == REQ_CHECK && roll < 60) a = last_addr + ($urandom % last_len);
    else a = $urandom_range(0, span - 1);
    roll = $urandom_range(0, 99);
    if (roll < 3) s = '0;
    else if (roll < 5) s = $urandom;
    else if (roll < 12) s = $urandom_range(1, 64 * gb);
    else s = $urandom_range(1, 4 * gb);
    if (kind == REQ_TAG) begin
      last_addr = a;
      last_len  = (s == '0) ? 1 : s;
      last_tag  = t;
    end else if (kind == REQ_CHECK && $urandom_range(0, 1) == 1) begin
      t = last_tag;
    end
    send_req(kind, a, s, t);
  endtask

  initial begin
    int unsigned mode;
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_TAG;
    req_ch.addr     <= '0;
    req_ch.size     <= '0;
    req_ch.tag      <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    recv_stall_pct  <= 0;
    hold_requests   <= 0;
    send_idle_pct   = 0;
    sent            = 0;
    cur_gran        = GRAN_RESET;
    cur_giu         = GIU_RESET;
    last_addr       = '0;
    last_len        = 1;
    last_tag        = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);

    // reset settings: 16-byte granules, full store
    send_req(REQ_CHECK, 32'h0000_0000, 32'd1, 8'h00);
    send_req(REQ_CHECK, 32'h0000_0000, 32'd1, 8'hFF);
    send_req(REQ_TAG,   32'h0000_0000, 32'd1, 8'hFF);
    send_req(REQ_CHECK, 32'h0000_000F, 32'd1, 8'hFF);
    send_req(REQ_CHECK, 32'h0000_0010, 32'd1, 8'hFF);
    send_req(REQ_TAG,   32'h0000_0020, 32'd0, 8'h77);
    send_req(REQ_TAG,   32'h0000_001F, 32'd2, 8'h5A);
    send_req(REQ_CLEAR, 32'h0000_0010, 32'd16, 8'hEE);
    send_req(REQ_CHECK, 32'h0000_0020, 32'd1, 8'h5A);
    send_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_req(REQ_TAG,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hA5);
    send_req(REQ_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
    send_req(REQ_TAG,   32'h0000_FFF0, 32'hFFFF_FFFF, 8'h3C);
    send_req(REQ_CHECK, 32'h0000_FFF0, 32'd1, 8'h3C);
    send_req(REQ_CHECK, 32'h0001_0000, 32'd1, 8'h00);
    send_req(REQ_TAG,   32'h0000_0000, 32'hFFFF_FFFF, 8'hC3);
    send_req(REQ_CHECK, 32'h0000_8000, 32'd1, 8'hC3);
    send_req(REQ_CLEAR, 32'h0000_0000, 32'h0001_0000, 8'h00);
    send_req(REQ_CHECK, 32'h0000_7FF0, 32'd1, 8'h00);
    send_req(REQ_TAG,   32'h0000_0100, 32'h0000_0040, 8'h81);
    send_req(REQ_CHECK, 32'h0000_013F, 32'd1, 8'h81);
    send_req(REQ_CHECK, 32'h0000_0140, 32'd1, 8'h81);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      cur_gran = (p == PHASES - 1) ? GRAN_W'($urandom_range(2, 300)) : GRAN_W'(GRAN_PLAN[p]);
      cur_giu  = (p == PHASES - 1) ? GIU_W'($urandom_range(1, TAG_ENTRIES))
                                   : GIU_W'(GIU_PLAN[p]);
      write_reg(GRAN_ADDR, ($urandom & ~32'h1FF) | CFG_DATA_W'(cur_gran));
      write_reg(GIU_ADDR, ($urandom & ~32'h1FFF) | CFG_DATA_W'(cur_giu));
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 63 : (mode == 3) ? 10 : 0;
      recv_stall_pct <= (mode == 2) ? 63 : (mode == 3) ? 10 : 0;
      if (p == 0) begin
        // hold the result side while requests keep coming
        hold_requests <= hold_requests + 1;
        repeat (12) send_req(REQ_CHECK, $urandom_range(0, 32'hFFFF), 32'd1, pick_tag());
      end
      repeat (ITEMS_PER_PHASE) random_request();
    end
    wait_idle();

    $display("Sent %0d requests: directed corner cases, then %0d register settings",
             sent, PHASES + 0);
    $display("under four idle patterns and a long result hold; %0d checks hit a tag.",
             tag_hits);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/gtss_pkg.sv
design/gtss_if.sv
design/gtss_div.sv
design/gtss_tag_mem.sv
design/granule_tag_shadow_store_core.sv
design/gtss_checker.sv
test/tag_store_checker.sv
test/tb_granule_tag_shadow_store_core.sv
